>>> design/lhq_pkg.sv
// Shared types, codes and constants for the leftist min-heap queue.
package lhq_pkg;

   localparam int DEFAULT_CAPACITY = 64;
   localparam int VALUE_W = 32;
   localparam int OCC_W = 7;

   localparam logic [1:0] FUNC_INSERT  = 2'd0;
   localparam logic [1:0] FUNC_GET_MIN = 2'd1;
   localparam logic [1:0] FUNC_DEL_MIN = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [1:0]                func;
      logic signed [VALUE_W-1:0] value;
   } lhq_req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] min_value;
      logic [1:0]                status;
      logic [OCC_W-1:0]          occupancy;
   } lhq_rsp_type;

   typedef struct packed {
      logic go;
      logic is_insert;
   } lhq_merge_cmd_type;

   typedef enum logic [2:0] {
      M_IDLE,
      M_SPLIT,
      M_LOAD_B,
      M_FETCH_A,
      M_COMPARE,
      M_ASCEND
   } lhq_merge_state_type;

   typedef enum logic [1:0] {
      T_IDLE,
      T_ALLOC,
      T_MERGE
   } lhq_top_state_type;

endpackage

>>> design/lhq_path_stack.sv
// LIFO of the nodes passed on the way down a merge, popped on the way back up.
module lhq_path_stack #(
   parameter int DEPTH = 14,
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic             pop,
   input  logic [WIDTH-1:0] push_data,
   output logic [WIDTH-1:0] top_data,
   output logic             empty
);

   localparam int PTR_W = $clog2(DEPTH + 1);
   localparam int IDX_W = $clog2(DEPTH);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] ptr_ff, ptr_in;
   logic [PTR_W-1:0] top_ptr;

   assign top_ptr  = ptr_ff - PTR_W'(1);
   assign top_data = entry_ff[top_ptr[IDX_W-1:0]];
   assign empty    = (ptr_ff == '0);

   always_comb begin
      ptr_in = ptr_ff;
      if (push) begin
         ptr_in = ptr_ff + PTR_W'(1);
      end else if (pop) begin
         ptr_in = top_ptr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= '0;
      end else begin
         ptr_ff <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[ptr_ff[IDX_W-1:0]] <= push_data;
      end
   end

endmodule

>>> design/lhq_merge_unit.sv
// Node memory and the sequencer that merges two leftist heaps along their right spines.
module lhq_merge_unit #(
   parameter int CAPACITY = lhq_pkg::DEFAULT_CAPACITY,
   localparam int IDX_W  = $clog2(CAPACITY),
   localparam int LINK_W = $clog2(CAPACITY + 1)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  lhq_pkg::lhq_merge_cmd_type        cmd,
   input  logic [LINK_W-1:0]                 root_link,
   input  logic [IDX_W-1:0]                  new_slot,
   input  logic signed [lhq_pkg::VALUE_W-1:0] new_value,
   output logic                              done,
   output logic [LINK_W-1:0]                 new_root,
   output logic signed [lhq_pkg::VALUE_W-1:0] new_root_value
);

   localparam int VW = lhq_pkg::VALUE_W;
   // rank = null-path length + 1, so an absent child has rank 0
   localparam int RANK_W = $clog2($clog2(CAPACITY + 1) + 1);
   localparam int STACK_DEPTH = 2 * $clog2(CAPACITY + 1);
   localparam int ENTRY_W = IDX_W + VW + LINK_W + RANK_W;
   localparam logic [LINK_W-1:0] NIL = LINK_W'(CAPACITY);

   // node memory, one field array each, common address
   logic signed [VW-1:0] value_ram [CAPACITY];
   logic [LINK_W-1:0]    left_ram  [CAPACITY];
   logic [LINK_W-1:0]    right_ram [CAPACITY];
   logic [RANK_W-1:0]    rank_ram  [CAPACITY];
   logic [RANK_W-1:0]    lrank_ram [CAPACITY];

   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic signed [VW-1:0] wr_value;
   logic [LINK_W-1:0]    wr_left, wr_right;
   logic [RANK_W-1:0]    wr_rank, wr_lrank;
   logic [IDX_W-1:0]     rd_addr;

   logic signed [VW-1:0] rd_value_ff;
   logic [LINK_W-1:0]    rd_left_ff, rd_right_ff;
   logic [RANK_W-1:0]    rd_rank_ff, rd_lrank_ff;

   lhq_pkg::lhq_merge_state_type state_ff, state_in;

   logic [LINK_W-1:0]    a_ff, a_in, b_ff, b_in;
   logic signed [VW-1:0] wb_value_ff, wb_value_in;
   logic [LINK_W-1:0]    wb_left_ff, wb_left_in, wb_right_ff, wb_right_in;
   logic [RANK_W-1:0]    wb_rank_ff, wb_rank_in, wb_lrank_ff, wb_lrank_in;
   logic [LINK_W-1:0]    r_ff, r_in;
   logic [RANK_W-1:0]    rr_ff, rr_in;
   logic signed [VW-1:0] rv_ff, rv_in;

   logic                 push, pop, stack_empty;
   logic [ENTRY_W-1:0]   push_data, top_data;
   logic [IDX_W-1:0]     top_slot;
   logic signed [VW-1:0] top_value;
   logic [LINK_W-1:0]    top_left;
   logic [RANK_W-1:0]    top_lrank;

   logic                 a_nil, a_greater, split_leaf;
   logic [LINK_W-1:0]    split_a, split_b;

   lhq_path_stack #(
      .DEPTH (STACK_DEPTH),
      .WIDTH (ENTRY_W)
   ) u_path_stack (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (pop),
      .push_data (push_data),
      .top_data  (top_data),
      .empty     (stack_empty)
   );

   assign top_lrank = top_data[RANK_W-1:0];
   assign top_left  = top_data[RANK_W +: LINK_W];
   assign top_value = top_data[RANK_W + LINK_W +: VW];
   assign top_slot  = top_data[RANK_W + LINK_W + VW +: IDX_W];

   assign a_nil     = (a_ff == NIL);
   assign a_greater = (rd_value_ff > wb_value_ff);
   assign split_leaf = (rd_left_ff == NIL) && (rd_right_ff == NIL);
   // keep the non-empty child in b
   assign split_b   = (rd_right_ff == NIL) ? rd_left_ff : rd_right_ff;
   assign split_a   = (rd_right_ff == NIL) ? NIL : rd_left_ff;

   assign new_root       = r_ff;
   assign new_root_value = rv_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lhq_pkg::M_IDLE: begin
            if (cmd.go) begin
               state_in = cmd.is_insert ? lhq_pkg::M_FETCH_A : lhq_pkg::M_SPLIT;
            end
         end
         lhq_pkg::M_SPLIT: begin
            state_in = split_leaf ? lhq_pkg::M_ASCEND : lhq_pkg::M_LOAD_B;
         end
         lhq_pkg::M_LOAD_B: begin
            state_in = lhq_pkg::M_FETCH_A;
         end
         lhq_pkg::M_FETCH_A: begin
            state_in = a_nil ? lhq_pkg::M_ASCEND : lhq_pkg::M_COMPARE;
         end
         lhq_pkg::M_COMPARE: begin
            state_in = lhq_pkg::M_FETCH_A;
         end
         lhq_pkg::M_ASCEND: begin
            if (stack_empty) begin
               state_in = lhq_pkg::M_IDLE;
            end
         end
         default: begin
            state_in = lhq_pkg::M_IDLE;
         end
      endcase
   end

   always_comb begin
      a_in        = a_ff;
      b_in        = b_ff;
      wb_value_in = wb_value_ff;
      wb_left_in  = wb_left_ff;
      wb_right_in = wb_right_ff;
      wb_rank_in  = wb_rank_ff;
      wb_lrank_in = wb_lrank_ff;
      r_in        = r_ff;
      rr_in       = rr_ff;
      rv_in       = rv_ff;
      wr_en       = 1'b0;
      wr_addr     = top_slot;
      wr_value    = top_value;
      wr_left     = top_left;
      wr_right    = r_ff;
      wr_rank     = rr_ff + RANK_W'(1);
      wr_lrank    = top_lrank;
      rd_addr     = a_ff[IDX_W-1:0];
      push        = 1'b0;
      pop         = 1'b0;
      push_data   = {a_ff[IDX_W-1:0], rd_value_ff, rd_left_ff, rd_lrank_ff};
      done        = 1'b0;
      case (state_ff)
         lhq_pkg::M_IDLE: begin
            if (cmd.go && cmd.is_insert) begin
               // new single-node heap goes to memory and straight into the b register
               wr_en       = 1'b1;
               wr_addr     = new_slot;
               wr_value    = new_value;
               wr_left     = NIL;
               wr_right    = NIL;
               wr_rank     = RANK_W'(1);
               wr_lrank    = '0;
               a_in        = root_link;
               b_in        = LINK_W'(new_slot);
               wb_value_in = new_value;
               wb_left_in  = NIL;
               wb_right_in = NIL;
               wb_rank_in  = RANK_W'(1);
               wb_lrank_in = '0;
            end else if (cmd.go) begin
               rd_addr = root_link[IDX_W-1:0];
            end
         end
         lhq_pkg::M_SPLIT: begin
            rd_addr = split_b[IDX_W-1:0];
            a_in    = split_a;
            b_in    = split_b;
            if (split_leaf) begin
               r_in  = NIL;
               rr_in = '0;
               rv_in = '0;
            end
         end
         lhq_pkg::M_LOAD_B: begin
            wb_value_in = rd_value_ff;
            wb_left_in  = rd_left_ff;
            wb_right_in = rd_right_ff;
            wb_rank_in  = rd_rank_ff;
            wb_lrank_in = rd_lrank_ff;
         end
         lhq_pkg::M_FETCH_A: begin
            if (a_nil) begin
               r_in  = b_ff;
               rr_in = wb_rank_ff;
               rv_in = wb_value_ff;
            end
         end
         lhq_pkg::M_COMPARE: begin
            push = 1'b1;
            if (a_greater) begin
               // b holds the smaller root: it stays on top, a's heap goes down its right spine
               push_data   = {b_ff[IDX_W-1:0], wb_value_ff, wb_left_ff, wb_lrank_ff};
               a_in        = wb_right_ff;
               b_in        = a_ff;
               wb_value_in = rd_value_ff;
               wb_left_in  = rd_left_ff;
               wb_right_in = rd_right_ff;
               wb_rank_in  = rd_rank_ff;
               wb_lrank_in = rd_lrank_ff;
            end else begin
               a_in = rd_right_ff;
            end
         end
         lhq_pkg::M_ASCEND: begin
            if (stack_empty) begin
               done = 1'b1;
            end else begin
               pop   = 1'b1;
               wr_en = 1'b1;
               if (top_lrank < rr_ff) begin
                  wr_left  = r_ff;
                  wr_right = top_left;
                  wr_lrank = rr_ff;
                  wr_rank  = top_lrank + RANK_W'(1);
               end
               r_in  = LINK_W'(top_slot);
               rr_in = wr_rank;
               rv_in = top_value;
            end
         end
         default: begin
            done = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lhq_pkg::M_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff        <= a_in;
      b_ff        <= b_in;
      wb_value_ff <= wb_value_in;
      wb_left_ff  <= wb_left_in;
      wb_right_ff <= wb_right_in;
      wb_rank_ff  <= wb_rank_in;
      wb_lrank_ff <= wb_lrank_in;
      r_ff        <= r_in;
      rr_ff       <= rr_in;
      rv_ff       <= rv_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         value_ram[wr_addr] <= wr_value;
         left_ram[wr_addr]  <= wr_left;
         right_ram[wr_addr] <= wr_right;
         rank_ram[wr_addr]  <= wr_rank;
         lrank_ram[wr_addr] <= wr_lrank;
      end
      rd_value_ff <= value_ram[rd_addr];
      rd_left_ff  <= left_ram[rd_addr];
      rd_right_ff <= right_ram[rd_addr];
      rd_rank_ff  <= rank_ram[rd_addr];
      rd_lrank_ff <= lrank_ram[rd_addr];
   end

endmodule

>>> design/leftist_min_heap_queue.sv
// Top level: request decode, free-slot stack, counters and result register.
//
//  channel | ports                    | direction | handshake
//  --------+--------------------------+-----------+-------------------------------
//  request | start, busy, req_item    | in        | taken when start & !busy
//  result  | rsp_valid, rsp_item      | out       | one-cycle strobe, no backpressure
//
// Get minimum, delete on an empty heap, insert on a full heap and the unused code answer in the
// cycle after the item is taken, with busy staying low.
// Insert and delete hold busy high until the merge is done; the merge passes the nodes of
// the merge path, at most 2*log2(CAPACITY+1) of them, one by one through the node memory.
// Synchronous reset empties the heap at once; there is no clearing pass.
module leftist_min_heap_queue #(
   parameter int CAPACITY = lhq_pkg::DEFAULT_CAPACITY
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  lhq_pkg::lhq_req_type req_item,
   output logic                 rsp_valid,
   output lhq_pkg::lhq_rsp_type rsp_item
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int VW = lhq_pkg::VALUE_W;
   localparam logic [CNT_W-1:0] NIL = CNT_W'(CAPACITY);

   lhq_pkg::lhq_top_state_type state_ff, state_in;

   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     hwm_ff, hwm_in;
   logic [CNT_W-1:0]     root_ff, root_in;
   logic signed [VW-1:0] root_value_ff, root_value_in;
   logic signed [VW-1:0] value_ff, value_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   lhq_pkg::lhq_rsp_type rsp_item_ff, rsp_item_in;

   // entries at or above the high-water mark were never written; such a slot is used as its own number
   logic [IDX_W-1:0]     free_ram [CAPACITY];
   logic [IDX_W-1:0]     free_rd_ff;
   logic [IDX_W-1:0]     free_rd_addr;
   logic                 free_wr;
   logic [IDX_W-1:0]     free_wr_addr;
   logic [CNT_W-1:0]     count_dec;

   lhq_pkg::lhq_merge_cmd_type merge_cmd;
   logic                 merge_done;
   logic [CNT_W-1:0]     merge_root;
   logic signed [VW-1:0] merge_root_value;
   logic [IDX_W-1:0]     alloc_slot;

   logic                 accept, full, empty;

   assign accept    = start && !busy;
   assign busy      = (state_ff != lhq_pkg::T_IDLE);
   assign full      = (count_ff == NIL);
   assign empty     = (root_ff == NIL) || (count_ff == '0);
   assign count_dec = count_ff - CNT_W'(1);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   assign free_rd_addr = full ? '0 : count_ff[IDX_W-1:0];
   assign free_wr_addr = count_dec[IDX_W-1:0];
   assign alloc_slot   = (count_ff == hwm_ff) ? count_ff[IDX_W-1:0] : free_rd_ff;

   lhq_merge_unit #(
      .CAPACITY (CAPACITY)
   ) u_merge_unit (
      .clock          (clock),
      .reset          (reset),
      .cmd            (merge_cmd),
      .root_link      (root_ff),
      .new_slot       (alloc_slot),
      .new_value      (value_ff),
      .done           (merge_done),
      .new_root       (merge_root),
      .new_root_value (merge_root_value)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lhq_pkg::T_IDLE: begin
            if (accept && (req_item.func == lhq_pkg::FUNC_INSERT) && !full) begin
               state_in = lhq_pkg::T_ALLOC;
            end else if (accept && (req_item.func == lhq_pkg::FUNC_DEL_MIN) && !empty) begin
               state_in = lhq_pkg::T_MERGE;
            end
         end
         lhq_pkg::T_ALLOC: begin
            state_in = lhq_pkg::T_MERGE;
         end
         lhq_pkg::T_MERGE: begin
            if (merge_done) begin
               state_in = lhq_pkg::T_IDLE;
            end
         end
         default: begin
            state_in = lhq_pkg::T_IDLE;
         end
      endcase
   end

   always_comb begin
      count_in      = count_ff;
      hwm_in        = hwm_ff;
      root_in       = root_ff;
      root_value_in = root_value_ff;
      value_in      = value_ff;
      rsp_valid_in  = 1'b0;
      rsp_item_in   = rsp_item_ff;
      merge_cmd     = '0;
      free_wr       = 1'b0;
      case (state_ff)
         lhq_pkg::T_IDLE: begin
            if (accept) begin
               value_in              = req_item.value;
               rsp_item_in.min_value = '0;
               rsp_item_in.status    = lhq_pkg::STATUS_OK;
               rsp_item_in.occupancy = lhq_pkg::OCC_W'(count_ff);
               case (req_item.func)
                  lhq_pkg::FUNC_INSERT: begin
                     if (full) begin
                        rsp_valid_in       = 1'b1;
                        rsp_item_in.status = lhq_pkg::STATUS_FULL;
                     end
                  end
                  lhq_pkg::FUNC_GET_MIN: begin
                     rsp_valid_in = 1'b1;
                     if (empty) begin
                        rsp_item_in.status = lhq_pkg::STATUS_EMPTY;
                     end else begin
                        rsp_item_in.min_value = root_value_ff;
                     end
                  end
                  lhq_pkg::FUNC_DEL_MIN: begin
                     if (empty) begin
                        rsp_valid_in       = 1'b1;
                        rsp_item_in.status = lhq_pkg::STATUS_EMPTY;
                     end else begin
                        merge_cmd.go        = 1'b1;
                        merge_cmd.is_insert = 1'b0;
                        free_wr             = 1'b1;
                        count_in            = count_dec;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         lhq_pkg::T_ALLOC: begin
            merge_cmd.go        = 1'b1;
            merge_cmd.is_insert = 1'b1;
            count_in            = count_ff + CNT_W'(1);
            if (count_ff == hwm_ff) begin
               hwm_in = hwm_ff + CNT_W'(1);
            end
         end
         lhq_pkg::T_MERGE: begin
            if (merge_done) begin
               root_in               = merge_root;
               root_value_in         = merge_root_value;
               rsp_valid_in          = 1'b1;
               rsp_item_in.min_value = '0;
               rsp_item_in.status    = lhq_pkg::STATUS_OK;
               rsp_item_in.occupancy = lhq_pkg::OCC_W'(count_ff);
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lhq_pkg::T_IDLE;
         count_ff     <= '0;
         hwm_ff       <= '0;
         root_ff      <= NIL;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         hwm_ff       <= hwm_in;
         root_ff      <= root_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      root_value_ff <= root_value_in;
      value_ff      <= value_in;
      rsp_item_ff   <= rsp_item_in;
   end

   always_ff @(posedge clock) begin
      if (free_wr) begin
         free_ram[free_wr_addr] <= root_ff[IDX_W-1:0];
      end
      free_rd_ff <= free_ram[free_rd_addr];
   end

   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while a request is in progress");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= NIL)
      else $error("stored count above capacity");

   a_root_matches_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lhq_pkg::T_IDLE) |-> ((root_ff == NIL) == (count_ff == '0)))
      else $error("heap root and stored count disagree");

   a_done_in_merge: assert property (@(posedge clock) disable iff (reset)
      merge_done |-> (state_ff == lhq_pkg::T_MERGE))
      else $error("merge finished outside of a merge");

   a_get_min_answers: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_item.func == lhq_pkg::FUNC_GET_MIN)) |=> rsp_valid)
      else $error("get minimum did not answer in the next cycle");

endmodule

>>> sim/tb.sv
// Testbench for the leftist min-heap queue: directed and random requests checked against a heap predictor.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAP = lhq_pkg::DEFAULT_CAPACITY;
   localparam int SLOT_W = $clog2(CAP);
   localparam int LINK_W = $clog2(CAP + 1);
   localparam logic [LINK_W-1:0] NO_NODE = LINK_W'(CAP);
   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 700;
   localparam logic signed [lhq_pkg::VALUE_W-1:0] MOST_NEG =
      {1'b1, {(lhq_pkg::VALUE_W-1){1'b0}}};
   localparam logic signed [lhq_pkg::VALUE_W-1:0] MOST_POS =
      {1'b0, {(lhq_pkg::VALUE_W-1){1'b1}}};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   lhq_pkg::lhq_req_type req_item = '0;
   logic rsp_valid;
   lhq_pkg::lhq_rsp_type rsp_item;

   leftist_min_heap_queue #(.CAPACITY(CAP)) i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predicted heap contents
   logic signed [lhq_pkg::VALUE_W-1:0] node_val [CAP];
   logic [LINK_W-1:0] left_of [CAP];
   logic [LINK_W-1:0] right_of [CAP];
   int npl [CAP];
   logic [LINK_W-1:0] heap_top = NO_NODE;
   logic [SLOT_W-1:0] free_stack [CAP];
   int heap_size = 0;

   lhq_pkg::lhq_req_type pending_reqs [$];
   lhq_pkg::lhq_rsp_type expected_rsps [$];

   int errors = 0;
   int checked = 0;
   int issued_by_func [4] = '{0, 0, 0, 0};
   int full_drops = 0;
   int empty_hits = 0;
   int peak_size = 0;

   // stimulus-side mirror of the occupancy, used to steer the random sequence
   int gen_size = 0;
   int gen_items = 0;

   initial begin
      for (int i = 0; i < CAP; i++) free_stack[i] = SLOT_W'(i);
   end

   function automatic int npl_at(input logic [LINK_W-1:0] n);
      return (n == NO_NODE) ? -1 : npl[n[SLOT_W-1:0]];
   endfunction

   // walk both right spines down, then fix links and null-path lengths on the way up
   function automatic logic [LINK_W-1:0] heap_merge(input logic [LINK_W-1:0] a_in,
                                                   input logic [LINK_W-1:0] b_in);
      logic [LINK_W-1:0] a, b, t, rest;
      logic [SLOT_W-1:0] ts;
      logic [LINK_W-1:0] spine [$];
      a = a_in;
      b = b_in;
      while (a != NO_NODE && b != NO_NODE) begin
         // strict compare: on a tie the stored heap stays on top
         if (node_val[a[SLOT_W-1:0]] > node_val[b[SLOT_W-1:0]]) begin
            t = a;
            a = b;
            b = t;
         end
         spine.push_back(a);
         a = right_of[a[SLOT_W-1:0]];
      end
      rest = (a != NO_NODE) ? a : b;
      while (spine.size() > 0) begin
         t = spine.pop_back();
         ts = t[SLOT_W-1:0];
         right_of[ts] = rest;
         if (npl_at(left_of[ts]) < npl_at(right_of[ts])) begin
            right_of[ts] = left_of[ts];
            left_of[ts] = rest;
         end
         npl[ts] = npl_at(right_of[ts]) + 1;
         rest = t;
      end
      return rest;
   endfunction

   task automatic predict_heap_op(input lhq_pkg::lhq_req_type r);
      lhq_pkg::lhq_rsp_type e;
      logic [SLOT_W-1:0] slot, old;
      e = '0;
      e.status = lhq_pkg::STATUS_OK;
      case (r.func)
         lhq_pkg::FUNC_INSERT: begin
            if (heap_size >= CAP) begin
               e.status = lhq_pkg::STATUS_FULL;
               full_drops++;
            end else begin
               slot = free_stack[SLOT_W'(heap_size)];
               heap_size++;
               node_val[slot] = r.value;
               left_of[slot] = NO_NODE;
               right_of[slot] = NO_NODE;
               npl[slot] = 0;
               heap_top = heap_merge(heap_top, LINK_W'(slot));
            end
         end
         lhq_pkg::FUNC_GET_MIN: begin
            if (heap_top == NO_NODE) begin
               e.status = lhq_pkg::STATUS_EMPTY;
               empty_hits++;
            end else begin
               e.min_value = node_val[heap_top[SLOT_W-1:0]];
            end
         end
         lhq_pkg::FUNC_DEL_MIN: begin
            if (heap_top == NO_NODE || heap_size == 0) begin
               e.status = lhq_pkg::STATUS_EMPTY;
               empty_hits++;
            end else begin
               old = heap_top[SLOT_W-1:0];
               heap_top = heap_merge(left_of[old], right_of[old]);
               heap_size--;
               free_stack[SLOT_W'(heap_size)] = old;
            end
         end
         default: ;
      endcase
      e.occupancy = lhq_pkg::OCC_W'(heap_size);
      if (heap_size > peak_size) peak_size = heap_size;
      expected_rsps.push_back(e);
   endtask

   // driver
   int gap_left = 0;
   logic no_idle = 1'b0;

   always @(posedge clock) begin
      logic next_start;
      lhq_pkg::lhq_req_type next_item;
      next_start = 1'b0;
      next_item = req_item;
      if (reset) begin
         gap_left = 0;
      end else begin
         if (start && !busy) begin
            predict_heap_op(req_item);
            issued_by_func[req_item.func]++;
            if ($urandom_range(0, 39) == 0) no_idle = !no_idle;
            gap_left = no_idle ? 0 : $urandom_range(0, 10);
         end
         if (start && busy) begin
            next_start = 1'b1;
         end else if (gap_left > 0) begin
            gap_left--;
         end else if (pending_reqs.size() > 0) begin
            next_item = pending_reqs.pop_front();
            next_start = 1'b1;
         end
      end
      start <= next_start;
      req_item <= next_item;
   end

   // monitor
   always @(posedge clock) begin
      lhq_pkg::lhq_rsp_type e;
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: result with nothing expected: %p", $time, rsp_item);
            errors++;
         end else begin
            e = expected_rsps.pop_front();
            checked++;
            if (rsp_item.min_value !== e.min_value) begin
               $display("%0t: min_value expected %0d actual %0d",
                        $time, e.min_value, rsp_item.min_value);
               errors++;
            end
            if (rsp_item.status !== e.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, e.status, rsp_item.status);
               errors++;
            end
            if (rsp_item.occupancy !== e.occupancy) begin
               $display("%0t: occupancy expected %0d actual %0d",
                        $time, e.occupancy, rsp_item.occupancy);
               errors++;
            end
         end
      end
   end

   function automatic logic signed [lhq_pkg::VALUE_W-1:0] draw_value();
      case ($urandom_range(0, 9))
         0: return MOST_NEG;
         1: return MOST_POS;
         2, 3, 4: return $signed($urandom_range(0, 15)) - 8;   // dense range, many duplicates
         default: return $urandom;
      endcase
   endfunction

   task automatic queue_req(input logic [1:0] f,
                            input logic signed [lhq_pkg::VALUE_W-1:0] v);
      lhq_pkg::lhq_req_type r;
      r.func = f;
      r.value = v;
      pending_reqs.push_back(r);
      if (f == lhq_pkg::FUNC_INSERT && gen_size < CAP) gen_size++;
      if (f == lhq_pkg::FUNC_DEL_MIN && gen_size > 0) gen_size--;
      if (f != FUNC_UNUSED) gen_items++;
   endtask

   initial begin
      int target, roll;
      logic [1:0] f;

      // directed: empty heap, unused code, value extremes, duplicates
      queue_req(lhq_pkg::FUNC_GET_MIN, $urandom);
      queue_req(lhq_pkg::FUNC_DEL_MIN, $urandom);
      queue_req(FUNC_UNUSED, $urandom);
      queue_req(lhq_pkg::FUNC_INSERT, MOST_POS);
      queue_req(lhq_pkg::FUNC_GET_MIN, $urandom);
      queue_req(lhq_pkg::FUNC_INSERT, MOST_NEG);
      queue_req(lhq_pkg::FUNC_GET_MIN, $urandom);
      queue_req(lhq_pkg::FUNC_INSERT, 0);
      queue_req(lhq_pkg::FUNC_INSERT, -1);
      queue_req(lhq_pkg::FUNC_INSERT, MOST_NEG);
      queue_req(lhq_pkg::FUNC_GET_MIN, $urandom);
      for (int i = 0; i < 5; i++) begin
         queue_req(lhq_pkg::FUNC_DEL_MIN, $urandom);
         queue_req(lhq_pkg::FUNC_GET_MIN, $urandom);
      end
      queue_req(lhq_pkg::FUNC_DEL_MIN, $urandom);
      for (int i = 0; i < 3; i++) queue_req(lhq_pkg::FUNC_INSERT, 5);
      queue_req(lhq_pkg::FUNC_DEL_MIN, $urandom);
      queue_req(lhq_pkg::FUNC_GET_MIN, $urandom);
      queue_req(lhq_pkg::FUNC_DEL_MIN, $urandom);
      queue_req(lhq_pkg::FUNC_DEL_MIN, $urandom);

      // random: walk the occupancy toward random targets, including full and empty
      gen_items = 0;
      target = CAP;
      while (gen_items < RANDOM_ITEMS) begin
         if (gen_size == target) begin
            f = (target == CAP) ? lhq_pkg::FUNC_INSERT :
                (target == 0)   ? lhq_pkg::FUNC_DEL_MIN : lhq_pkg::FUNC_GET_MIN;
            repeat ($urandom_range(1, 3)) queue_req(f, draw_value());
            case ($urandom_range(0, 3))
               0: target = 0;
               1: target = CAP;
               default: target = $urandom_range(1, CAP - 1);
            endcase
         end
         roll = $urandom_range(0, 99);
         if (roll < 30)
            f = lhq_pkg::FUNC_GET_MIN;
         else if (roll < 85)
            f = (gen_size < target) ? lhq_pkg::FUNC_INSERT : lhq_pkg::FUNC_DEL_MIN;
         else if (roll < 97)
            f = (gen_size < target) ? lhq_pkg::FUNC_DEL_MIN : lhq_pkg::FUNC_INSERT;
         else
            f = FUNC_UNUSED;
         queue_req(f, (f == lhq_pkg::FUNC_INSERT) ? draw_value() : $signed($urandom));
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() > 0 || start || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (100) @(posedge clock);

      $display("Ran %0d inserts, %0d get-min, %0d delete-min, %0d unused-code items; %0d results",
               issued_by_func[lhq_pkg::FUNC_INSERT], issued_by_func[lhq_pkg::FUNC_GET_MIN],
               issued_by_func[lhq_pkg::FUNC_DEL_MIN], issued_by_func[FUNC_UNUSED], checked);
      $display("Heap reached %0d entries; %0d dropped inserts on a full pool, %0d empty hits",
               peak_size, full_drops, empty_hits);
      if (errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("timeout with %0d results outstanding", expected_rsps.size());
      $display("FAIL");
      $finish;
   end

endmodule

>>> filelist.f
design/lhq_pkg.sv
design/lhq_path_stack.sv
design/lhq_merge_unit.sv
design/leftist_min_heap_queue.sv
sim/tb.sv
